### rtl/mwsl_pkg.sv
`timescale 1ns / 1ps
// Shared types for the max window sum block: controller states and the
// command and status groups between controller and datapath. No dependencies.
package mwsl_pkg;

	localparam int LIMIT_W = 32;
	// limit plus one more value: the widest the window total gets before pops
	localparam int TOTAL_W = LIMIT_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FULL_RD,
		ST_FULL_POP,
		ST_PUSH,
		ST_CHECK,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_in;   // capture the accepted item
		logic rd_head;   // read the oldest window entry
		logic pop;       // drop the oldest entry using the read data
		logic set_ovf;   // mark overflow
		logic push;      // append the held value
		logic upd_best;  // fold the total into the best sum
		logic emit;      // load the result and clear the run
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
		logic over;
		logic last;
		logic out_busy;
	} sts_t;

endpackage

### rtl/mwsl_ctrl.sv
`timescale 1ns / 1ps
// Controller for the max window sum block: sequences push, pops and result.
// Depends on mwsl_pkg.
module mwsl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mwsl_pkg::sts_t sts,
	output mwsl_pkg::cmd_t cmd
);
	import mwsl_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = sts.full ? ST_FULL_RD : ST_PUSH;
				end
			end
			ST_FULL_RD:  state_nx = ST_FULL_POP;
			ST_FULL_POP: state_nx = ST_PUSH;
			ST_PUSH:     state_nx = ST_CHECK;
			ST_CHECK: begin
				if (sts.nonempty && sts.over) begin
					state_nx = ST_POP;
				end else begin
					state_nx = sts.last ? ST_EMIT : ST_IDLE;
				end
			end
			ST_POP: state_nx = ST_CHECK;
			ST_EMIT: begin
				if (!sts.out_busy) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_FULL_RD: cmd.rd_head = 1'b1;
			ST_FULL_POP: begin
				cmd.pop     = 1'b1;
				cmd.set_ovf = 1'b1;
			end
			ST_PUSH: cmd.push = 1'b1;
			ST_CHECK: begin
				if (sts.nonempty && sts.over) begin
					cmd.rd_head = 1'b1;
				end else begin
					cmd.upd_best = 1'b1;
				end
			end
			ST_POP:  cmd.pop  = 1'b1;
			ST_EMIT: cmd.emit = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

### rtl/mwsl_dp.sv
`timescale 1ns / 1ps
// Datapath for the max window sum block: window memory, pointers, total,
// best sum, limit register and result register. Depends on mwsl_pkg.
module mwsl_dp #(
	parameter int MAX_WINDOW = 1024,
	parameter int VALUE_BITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [VALUE_BITS-1:0]       in_value,
	input  logic                        in_last,
	input  logic                        cfg_we,
	input  logic [mwsl_pkg::LIMIT_W-1:0] cfg_data,
	input  mwsl_pkg::cmd_t              cmd,
	output mwsl_pkg::sts_t              sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mwsl_pkg::LIMIT_W-1:0] out_best_sum,
	output logic                        out_overflow
);
	import mwsl_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(MAX_WINDOW - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_WINDOW);

	logic [VALUE_BITS-1:0] mem [MAX_WINDOW];
	logic [VALUE_BITS-1:0] rd_data_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  last_q;
	logic [AW-1:0]         head_q, tail_q;
	logic [CW-1:0]         count_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [LIMIT_W-1:0]    best_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	logic [LIMIT_W-1:0]    out_best_q;
	logic                  out_ovf_q;
	logic                  over;

	assign over = total_q > TOTAL_W'(limit_q);

	assign sts.full     = count_q == CNT_FULL;
	assign sts.nonempty = count_q != '0;
	assign sts.over     = over;
	assign sts.last     = last_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	// window memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= value_q;
		end
		if (cmd.rd_head) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			value_q <= in_value;
			last_q  <= in_last;
		end
		if (cmd.emit) begin
			out_best_q <= best_q;
			out_ovf_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			total_q <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.emit) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			total_q <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.pop) begin
				total_q <= total_q - TOTAL_W'(rd_data_q);
				head_q  <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.push) begin
				total_q <= total_q + TOTAL_W'(value_q);
				tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			// total is at most limit here, so it fits the best register
			if (cmd.upd_best && (total_q > TOTAL_W'(best_q))) begin
				best_q <= total_q[LIMIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_best_sum = out_best_q;
	assign out_overflow = out_ovf_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("window count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop from empty window");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q != CNT_FULL)
		else $error("push into full window");
	a_best_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_best |-> !over)
		else $error("best sum updated with total above limit");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !out_ready))
		else $error("result overwritten before taken");
`endif

endmodule

### rtl/max_window_sum_under_limit.sv
`timescale 1ns / 1ps
// Largest contiguous window sum not above a limit, over a stream of values.
// An accepted item is pushed and then checked against the limit; every entry
// dropped from the oldest end of the window takes a read step and a subtract
// step, and when the window already holds MAX_WINDOW values its oldest entry is
// read and dropped before the push. The item marked last adds a step to load the
// result. The single window memory with its registered read sets these steps.
// Each value is dropped at most once; no new item is taken until the previous is done.
// The result register lets the next run start while a result waits.
// Depends on mwsl_pkg, mwsl_ctrl and mwsl_dp.
module max_window_sum_under_limit #(
	parameter int MAX_WINDOW = 1024,
	parameter int VALUE_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // value, zero padded
	input  logic                              s_tlast,  // last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mwsl_pkg::LIMIT_W-1:0]      m_tdata,  // best_sum
	output logic                              m_tuser,  // overflow
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mwsl_pkg::LIMIT_W-1:0]      cfg_data  // limit
);
	import mwsl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mwsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mwsl_dp #(
		.MAX_WINDOW (MAX_WINDOW),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_value     (s_tdata[VALUE_BITS-1:0]),
		.in_last      (s_tlast),
		.cfg_we       (cfg_valid),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_best_sum (m_tdata),
		.out_overflow (m_tuser)
	);

endmodule

### verif/mwsl_checker.sv
`timescale 1ns / 1ps
// Scoreboard for max_window_sum_under_limit: watches the limit, input and result
// channels, predicts each run's best sum and overflow flag, and compares results.
// Depends on mwsl_pkg for the result width.
module mwsl_checker #(
	parameter int MAX_WINDOW = 1024,
	parameter int VALUE_BITS = 20,
	parameter int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [TDATA_W-1:0]           s_tdata,   // value, zero padded
	input  logic                         s_tlast,   // last
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [mwsl_pkg::LIMIT_W-1:0] m_tdata,   // best_sum
	input  logic                         m_tuser,   // overflow
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [mwsl_pkg::LIMIT_W-1:0] cfg_data,  // limit
	output int                           mismatches,
	output int                           results_pending,
	output int                           results_seen,
	output int                           overflow_results,
	output int                           items_seen
);

	typedef struct packed {
		logic [mwsl_pkg::LIMIT_W-1:0] best_sum;
		logic                         overflow;
	} run_result_t;

	run_result_t                    expected_sums[$];
	logic [VALUE_BITS-1:0]          held_values[$];
	logic [mwsl_pkg::TOTAL_W-1:0]   held_total;
	logic [mwsl_pkg::LIMIT_W-1:0]   best_total;
	logic                           overflow_flag;
	logic [mwsl_pkg::LIMIT_W-1:0]   limit_reg;
	int                             err_n;
	int                             res_n;
	int                             ovf_n;
	int                             item_n;

	function void clear_run();
		held_values.delete();
		held_total    = '0;
		best_total    = '0;
		overflow_flag = 1'b0;
	endfunction

	// Push one value (first dropping the oldest if full), shrink the window from the
	// oldest end until it fits the limit, and queue the result when the run ends.
	function void fold_value(input logic [VALUE_BITS-1:0] v, input logic ends_run);
		run_result_t r;
		if (held_values.size() >= MAX_WINDOW) begin
			overflow_flag = 1'b1;
			held_total -= held_values.pop_front();
		end
		held_values.insert(held_values.size(), v);
		held_total += v;
		while (held_values.size() > 0 && held_total > {1'b0, limit_reg})
			held_total -= held_values.pop_front();
		if (held_total > {1'b0, best_total})
			best_total = held_total[mwsl_pkg::LIMIT_W-1:0];
		if (ends_run) begin
			r.best_sum = best_total;
			r.overflow = overflow_flag;
			expected_sums.insert(expected_sums.size(), r);
			clear_run();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		run_result_t want;
		if (!arst_n) begin
			clear_run();
			expected_sums.delete();
			limit_reg = '0;
			err_n     = 0;
			res_n     = 0;
			ovf_n     = 0;
			item_n    = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			if (s_tvalid && s_tready) begin
				item_n++;
				fold_value(s_tdata[VALUE_BITS-1:0], s_tlast);
			end
			if (m_tvalid && m_tready) begin
				res_n++;
				if (m_tuser)
					ovf_n++;
				if (expected_sums.size() == 0) begin
					err_n++;
					if (err_n <= 10)
						$display("%0t: result with none expected: best_sum=%0d overflow=%0b",
							$realtime, m_tdata, m_tuser);
				end else begin
					want = expected_sums.pop_front();
					if (m_tdata !== want.best_sum || m_tuser !== want.overflow) begin
						err_n++;
						if (err_n <= 10) begin
							$display("%0t: result %0d: best_sum exp %0d got %0d",
								$realtime, res_n, want.best_sum, m_tdata);
							$display("%0t: result %0d: overflow exp %0b got %0b",
								$realtime, res_n, want.overflow, m_tuser);
						end
					end
				end
			end
		end
		// publish after the edge so the stimulus side samples settled counts
		mismatches       <= err_n;
		results_pending  <= expected_sums.size();
		results_seen     <= res_n;
		overflow_results <= ovf_n;
		items_seen       <= item_n;
	end

endmodule

### verif/max_window_sum_under_limit_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for max_window_sum_under_limit: directed runs, one overflow
// run and random runs under several limits. Depends on mwsl_pkg, mwsl_checker and the design.
module max_window_sum_under_limit_tb;

	localparam int MAX_WINDOW  = 1024;
	localparam int VALUE_BITS  = 20;
	localparam int TDATA_W     = ((VALUE_BITS + 7) / 8) * 8;
	localparam int SETTLE      = 2 * MAX_WINDOW + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 300;
	localparam int RANDOM_PHASES = 6;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	typedef enum int {
		VAL_MIX,
		VAL_SMALL
	} value_mode_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [TDATA_W-1:0]           s_tdata;   // value, zero padded
	logic                         s_tlast;   // last
	logic                         m_tvalid;
	logic                         m_tready;
	logic [mwsl_pkg::LIMIT_W-1:0] m_tdata;   // best_sum
	logic                         m_tuser;   // overflow
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [mwsl_pkg::LIMIT_W-1:0] cfg_data;  // limit

	int   mismatches;
	int   results_pending;
	int   results_seen;
	int   overflow_results;
	int   items_seen;
	int   cycle_count = 0;
	int   burst_left;
	int   limit_writes;
	logic no_gaps;
	logic hold_off;
	logic hold_done;

	max_window_sum_under_limit #(
		.MAX_WINDOW(MAX_WINDOW),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	mwsl_checker #(
		.MAX_WINDOW(MAX_WINDOW),
		.VALUE_BITS(VALUE_BITS)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.results_pending(results_pending),
		.results_seen(results_seen),
		.overflow_results(overflow_results),
		.items_seen(items_seen)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				results_pending);
			$display("max_window_sum_under_limit_tb NOT OK");
			$finish;
		end
	end

	// Receiver: ready follows one of four patterns, picked anew after a random stretch,
	// and once holds off for a long stretch on request.
	initial begin
		int mode;
		int mode_left;
		mode_left = 0;
		mode      = 0;
		m_tready  = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (cycle_count[3:0] < 4'd11);
				endcase
			end
		end
	end

	function automatic logic [VALUE_BITS-1:0] pick_value(value_mode_t mode);
		int r;
		r = $urandom_range(0, 7);
		if (mode == VAL_SMALL)
			return (r == 0) ? VALUE_BITS'($urandom()) : VALUE_BITS'($urandom_range(0, 15));
		case (r)
			0: return '0;
			1: return VALUE_MAX;
			2, 3: return VALUE_BITS'($urandom_range(0, 31));
			default: return VALUE_BITS'($urandom());
		endcase
	endfunction

	// Offer one item; between bursts of random length insert a random gap.
	task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic ends_run);
		int gap;
		if (burst_left == 0) begin
			gap        = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(v);
		s_tlast  <= ends_run;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering, hold until every predicted result has come back, then settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limit(input logic [mwsl_pkg::LIMIT_W-1:0] lim);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_writes++;
	endtask

	task automatic send_run(input int len, input value_mode_t mode);
		for (int i = 0; i < len; i++)
			send_item(pick_value(mode), i == len - 1);
	endtask

	initial begin
		int          sent;
		int          len;
		int          target;
		value_mode_t mode;
		logic [mwsl_pkg::LIMIT_W-1:0] lim;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		hold_off     = 1'b0;
		no_gaps      = 1'b0;
		burst_left   = 0;
		limit_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limit still at its reset value: every nonzero value is dropped at once
		send_item(0, 1'b0);
		send_item(1, 1'b0);
		send_item(VALUE_MAX, 1'b1);

		set_limit('1);
		send_item(VALUE_MAX, 1'b0);
		send_item(20'hAAAAA, 1'b0);
		send_item(20'h55555, 1'b0);
		send_item(VALUE_MAX, 1'b1);
		send_item(7, 1'b1);

		// pop from the oldest end, hit the limit exactly, then a lone value above it
		set_limit(100);
		send_item(30, 1'b0);
		send_item(40, 1'b0);
		send_item(50, 1'b0);
		send_item(10, 1'b0);
		send_item(101, 1'b0);
		send_item(0, 1'b0);
		send_item(60, 1'b1);

		set_limit(32'(VALUE_MAX));
		send_item(VALUE_MAX, 1'b0);
		send_item(1, 1'b0);
		send_item(0, 1'b1);

		set_limit(0);
		send_item(0, 1'b1);

		// one run longer than the window so it wraps and sets overflow
		set_limit('1);
		send_run(MAX_WINDOW + 6, VAL_MIX);

		sent = 0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			mode = VAL_MIX;
			case (p)
				0: lim = $urandom_range(1 << 20, 1 << 23);
				1: begin
					lim  = $urandom_range(0, 48);
					mode = VAL_SMALL;
				end
				2: lim = '1;
				3: lim = $urandom();
				4: lim = $urandom_range(0, 32'(VALUE_MAX));
				default: lim = $urandom_range(1 << 21, 1 << 24);
			endcase
			set_limit(lim);
			no_gaps <= (p == RANDOM_PHASES - 1);
			// stall the result side for a long stretch while items keep coming
			if (p == 1)
				hold_off <= 1'b1;
			target = RANDOM_ITEMS * (p + 1) / RANDOM_PHASES;
			while (sent < target) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16);
				send_run(len, mode);
				sent += len;
			end
		end

		drain_results();
		$display("covered %0d items and %0d results (%0d with overflow) over %0d limit settings",
			items_seen, results_seen, overflow_results, limit_writes + 1);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("max_window_sum_under_limit_tb OK");
		else
			$display("max_window_sum_under_limit_tb NOT OK");
		$finish;
	end

endmodule
